// ===== src/lasp_pkg.sv =====
// shared types and constants of the buffer slot planner
// no dependencies
package lasp_pkg;

    localparam int MAX_BUFFERS_DEF = 64;
    localparam int SIZE_BITS_DEF   = 32;
    localparam int BYTES_W         = 32;
    localparam int STEP_W          = 10;
    localparam int INDEX_W         = 6;
    localparam int OWNER_W         = 7;
    localparam int OUT_W           = 38;

    localparam logic [OWNER_W-1:0] OWNER_NONE = '1;

    typedef struct packed {
        logic [BYTES_W-1:0] bytes;
        logic [STEP_W-1:0]  first;
        logic [STEP_W-1:0]  final_s;
        logic [INDEX_W-1:0] idx;
        logic               run_end;
    } t_desc;

    typedef struct packed {
        logic [INDEX_W-1:0] buf_index;
        logic [OUT_W-1:0]   byte_offset;
        logic [OWNER_W-1:0] reuses_owner;
        logic [OUT_W-1:0]   arena_total;
        logic [OUT_W-1:0]   bytes_saved;
        logic [OUT_W-1:0]   peak_live;
        logic               run_end;
    } t_result;

endpackage

// ===== src/lasp_fifo.sv =====
// two-entry queue used between front, planner and result ports
// no package dependency
module lasp_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_rd,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         wr_ok;
    logic         rd_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_ok) begin
                r_wp <= ~r_wp;
            end
            if (rd_ok) begin
                r_rp <= ~r_rp;
            end
            case ({wr_ok, rd_ok})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// ===== src/lasp_front.sv =====
// front end: takes descriptor requests, tags index and end of run
// depends on lasp_pkg
module lasp_front #(
    parameter int MAX_BUFFERS = lasp_pkg::MAX_BUFFERS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [lasp_pkg::BYTES_W-1:0]       i_buf_bytes,
    input  logic [lasp_pkg::STEP_W-1:0]        i_first_step,
    input  logic [lasp_pkg::STEP_W-1:0]        i_final_step,
    input  logic                               i_is_last,
    output logic                               o_q_wr,
    output lasp_pkg::t_desc                    o_q_data,
    input  logic                               i_q_full
);
    localparam int IW = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;

    logic [IW-1:0] r_count;
    logic          at_end;

    assign full   = i_q_full;
    assign o_q_wr = push && !i_q_full;
    assign at_end = i_is_last || (r_count == IW'(MAX_BUFFERS - 1));

    always_comb begin
        o_q_data.bytes   = i_buf_bytes;
        o_q_data.first   = i_first_step;
        o_q_data.final_s = i_final_step;
        o_q_data.idx     = lasp_pkg::INDEX_W'(r_count);
        o_q_data.run_end = at_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_q_wr) begin
            r_count <= at_end ? '0 : r_count + IW'(1);
        end
    end
endmodule

// ===== src/lasp_plan.sv =====
// back end: stores descriptors, ranks by size, assigns slots, packs
// offsets, sums totals and peak, then emits results; depends on lasp_pkg
module lasp_plan #(
    parameter int MAX_BUFFERS = lasp_pkg::MAX_BUFFERS_DEF,
    parameter int SIZE_BITS   = lasp_pkg::SIZE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_empty,
    input  lasp_pkg::t_desc   i_in,
    output logic              o_in_take,
    input  logic              i_res_full,
    output logic              o_res_push,
    output lasp_pkg::t_result o_res
);
    localparam int IW = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
    localparam int CW = IW + 1;
    localparam int AW = (SIZE_BITS + 7 > lasp_pkg::OUT_W) ? SIZE_BITS + 7 : lasp_pkg::OUT_W;
    localparam int SW = lasp_pkg::STEP_W;

    typedef enum logic [4:0] {
        S_LOAD, S_RK_HEAD, S_RK_LATCH, S_RK_SCAN,
        S_AS_HEAD, S_AS_ORD, S_AS_DESC, S_AS_MEM, S_AS_SLOT, S_AS_FIN,
        S_OF_SCAN, S_NV_SCAN, S_PK_HEAD, S_PK_LATCH, S_PK_SCAN,
        S_OUT_HEAD, S_OUT_SL, S_OUT_DAT
    } t_state;

    t_state r_state;

    // memories
    logic [SIZE_BITS-1:0] m_bytes [MAX_BUFFERS];
    logic [SW-1:0]        m_first [MAX_BUFFERS];
    logic [SW-1:0]        m_final [MAX_BUFFERS];
    logic [IW-1:0]        m_rank  [MAX_BUFFERS];
    logic [IW-1:0]        m_order [MAX_BUFFERS];
    logic [IW-1:0]        m_slot  [MAX_BUFFERS];
    logic [SIZE_BITS-1:0] m_sbytes[MAX_BUFFERS];
    logic [IW-1:0]        m_owner [MAX_BUFFERS];
    logic [CW-1:0]        m_clash [MAX_BUFFERS];
    logic [AW-1:0]        m_offs  [MAX_BUFFERS];

    logic [SIZE_BITS-1:0] bytes_q;
    logic [SW-1:0]        first_q;
    logic [SW-1:0]        final_q;
    logic [IW-1:0]        rank_q;
    logic [IW-1:0]        order_q;
    logic [IW-1:0]        slot_q;
    logic [SIZE_BITS-1:0] sbytes_q;
    logic [IW-1:0]        owner_q;
    logic [CW-1:0]        clash_q;
    logic [AW-1:0]        offs_q;

    // control and datapath registers
    logic [CW-1:0]        r_n;
    logic [CW-1:0]        r_slots;
    logic [CW-1:0]        r_b;
    logic [CW-1:0]        r_k;
    logic [CW-1:0]        r_i;
    logic [CW-1:0]        r_j;
    logic                 r_dv;
    logic [IW-1:0]        r_dj;
    logic [CW-1:0]        r_cnt;
    logic [IW-1:0]        r_cb;
    logic [SIZE_BITS-1:0] r_sz;
    logic [SW-1:0]        r_f;
    logic [SW-1:0]        r_l;
    logic                 r_best_v;
    logic [IW-1:0]        r_best;
    logic [SIZE_BITS-1:0] r_waste;
    logic [AW-1:0]        r_total;
    logic [AW-1:0]        r_naive;
    logic [AW-1:0]        r_peak;
    logic [AW-1:0]        r_alive;

    logic          is_scan;
    logic [CW-1:0] scan_lim;
    logic          issue;
    logic          scan_done;
    logic [IW-1:0] desc_ra;
    logic [IW-1:0] slot_ra;
    logic          desc_we;
    logic          rk_we;
    logic          fin_we;
    logic          new_slot;
    logic          clash_we;
    logic [IW-1:0] clash_wa;
    logic [CW-1:0] clash_wd;
    logic          offs_we;
    logic          ahead;
    logic          meets;
    logic          fits;
    logic [SIZE_BITS-1:0] waste;
    logic [AW-1:0] saved;

    assign is_scan = (r_state == S_RK_SCAN) || (r_state == S_AS_MEM) ||
                     (r_state == S_AS_SLOT) || (r_state == S_OF_SCAN) ||
                     (r_state == S_NV_SCAN) || (r_state == S_PK_SCAN);
    assign scan_lim  = ((r_state == S_AS_SLOT) || (r_state == S_OF_SCAN)) ? r_slots : r_n;
    assign issue     = r_j < scan_lim;
    assign scan_done = !issue && !r_dv;

    assign ahead  = (bytes_q > r_sz) || ((bytes_q == r_sz) && (r_dj < r_b[IW-1:0]));
    assign meets  = !((r_l < first_q) || (final_q < r_f));
    assign fits   = (sbytes_q >= r_sz) && (clash_q != r_k);
    assign waste  = sbytes_q - r_sz;
    assign saved  = (r_naive > r_total) ? r_naive - r_total : '0;

    always_comb begin
        case (r_state)
            S_RK_HEAD: desc_ra = r_b[IW-1:0];
            S_AS_ORD:  desc_ra = order_q;
            S_PK_HEAD: desc_ra = r_i[IW-1:0];
            default:   desc_ra = r_j[IW-1:0];
        endcase
        if (r_state == S_OUT_HEAD || r_state == S_OUT_SL || r_state == S_OUT_DAT) begin
            slot_ra = r_i[IW-1:0];
        end else begin
            slot_ra = r_j[IW-1:0];
        end
    end

    assign o_in_take = (r_state == S_LOAD) && !i_in_empty;
    assign desc_we   = o_in_take;
    assign rk_we     = (r_state == S_RK_SCAN) && scan_done;
    assign fin_we    = (r_state == S_AS_FIN);
    assign new_slot  = fin_we && !r_best_v;
    assign offs_we   = (r_state == S_OF_SCAN) && r_dv;

    always_comb begin
        clash_we = 1'b0;
        clash_wa = slot_q;
        clash_wd = r_k;
        if (r_state == S_AS_MEM && r_dv && (CW'(rank_q) < r_k) && meets) begin
            clash_we = 1'b1;
        end else if (new_slot) begin
            clash_we = 1'b1;
            clash_wa = r_slots[IW-1:0];
            clash_wd = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (desc_we) begin
            m_bytes[i_in.idx[IW-1:0]] <= SIZE_BITS'(i_in.bytes);
            m_first[i_in.idx[IW-1:0]] <= i_in.first;
            m_final[i_in.idx[IW-1:0]] <= i_in.final_s;
        end
        bytes_q <= m_bytes[desc_ra];
        first_q <= m_first[desc_ra];
        final_q <= m_final[desc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rk_we) begin
            m_rank[r_b[IW-1:0]] <= r_cnt[IW-1:0];
        end
        rank_q <= m_rank[r_j[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (rk_we) begin
            m_order[r_cnt[IW-1:0]] <= r_b[IW-1:0];
        end
        order_q <= m_order[r_k[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (fin_we) begin
            m_slot[r_cb] <= r_best_v ? r_best : r_slots[IW-1:0];
        end
        slot_q <= m_slot[slot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (new_slot) begin
            m_sbytes[r_slots[IW-1:0]] <= r_sz;
        end
        sbytes_q <= m_sbytes[r_j[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (new_slot) begin
            m_owner[r_slots[IW-1:0]] <= r_cb;
        end
        owner_q <= m_owner[slot_q];
    end

    always_ff @(posedge i_clk) begin
        if (clash_we) begin
            m_clash[clash_wa] <= clash_wd;
        end
        clash_q <= m_clash[r_j[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (offs_we) begin
            m_offs[r_dj] <= r_total;
        end
        offs_q <= m_offs[slot_q];
    end

    always_comb begin
        o_res.buf_index    = lasp_pkg::INDEX_W'(r_i[IW-1:0]);
        o_res.byte_offset  = offs_q[lasp_pkg::OUT_W-1:0];
        o_res.reuses_owner = (owner_q == r_i[IW-1:0]) ? lasp_pkg::OWNER_NONE
                                                       : lasp_pkg::OWNER_W'(owner_q);
        o_res.arena_total  = r_total[lasp_pkg::OUT_W-1:0];
        o_res.bytes_saved  = saved[lasp_pkg::OUT_W-1:0];
        o_res.peak_live    = r_peak[lasp_pkg::OUT_W-1:0];
        o_res.run_end      = (r_i + CW'(1)) == r_n;
    end
    assign o_res_push = (r_state == S_OUT_DAT) && !i_res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_n     <= '0;
            r_slots <= '0;
            r_dv    <= 1'b0;
            r_j     <= '0;
        end else begin
            if (is_scan) begin
                if (issue) begin
                    r_j <= r_j + CW'(1);
                end
                r_dv <= issue;
                r_dj <= r_j[IW-1:0];
            end
            case (r_state)
                S_LOAD: begin
                    if (o_in_take) begin
                        r_n <= CW'(i_in.idx[IW-1:0]) + CW'(1);
                        if (i_in.run_end) begin
                            r_b     <= '0;
                            r_state <= S_RK_HEAD;
                        end
                    end
                end
                S_RK_HEAD: r_state <= S_RK_LATCH;
                S_RK_LATCH: begin
                    r_sz    <= bytes_q;
                    r_cnt   <= '0;
                    r_j     <= '0;
                    r_dv    <= 1'b0;
                    r_state <= S_RK_SCAN;
                end
                S_RK_SCAN: begin
                    if (r_dv && ahead) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (scan_done) begin
                        r_b <= r_b + CW'(1);
                        if (r_b + CW'(1) == r_n) begin
                            r_k     <= '0;
                            r_state <= S_AS_HEAD;
                        end else begin
                            r_state <= S_RK_HEAD;
                        end
                    end
                end
                S_AS_HEAD: r_state <= S_AS_ORD;
                S_AS_ORD: begin
                    r_cb    <= order_q;
                    r_state <= S_AS_DESC;
                end
                S_AS_DESC: begin
                    r_sz    <= bytes_q;
                    r_f     <= first_q;
                    r_l     <= final_q;
                    r_j     <= '0;
                    r_dv    <= 1'b0;
                    r_state <= S_AS_MEM;
                end
                S_AS_MEM: begin
                    if (scan_done) begin
                        r_j      <= '0;
                        r_best_v <= 1'b0;
                        r_state  <= S_AS_SLOT;
                    end
                end
                S_AS_SLOT: begin
                    if (r_dv && fits && (!r_best_v || waste < r_waste)) begin
                        r_best_v <= 1'b1;
                        r_best   <= r_dj;
                        r_waste  <= waste;
                    end
                    if (scan_done) begin
                        r_state <= S_AS_FIN;
                    end
                end
                S_AS_FIN: begin
                    if (!r_best_v) begin
                        r_slots <= r_slots + CW'(1);
                    end
                    r_k <= r_k + CW'(1);
                    if (r_k + CW'(1) == r_n) begin
                        r_j     <= '0;
                        r_total <= '0;
                        r_state <= S_OF_SCAN;
                    end else begin
                        r_state <= S_AS_HEAD;
                    end
                end
                S_OF_SCAN: begin
                    if (r_dv) begin
                        r_total <= r_total + AW'(sbytes_q);
                    end
                    if (scan_done) begin
                        r_j     <= '0;
                        r_naive <= '0;
                        r_state <= S_NV_SCAN;
                    end
                end
                S_NV_SCAN: begin
                    if (r_dv) begin
                        r_naive <= r_naive + AW'(bytes_q);
                    end
                    if (scan_done) begin
                        r_i     <= '0;
                        r_peak  <= '0;
                        r_state <= S_PK_HEAD;
                    end
                end
                S_PK_HEAD: r_state <= S_PK_LATCH;
                S_PK_LATCH: begin
                    r_f     <= first_q;
                    r_alive <= '0;
                    r_j     <= '0;
                    r_dv    <= 1'b0;
                    if (first_q <= final_q) begin
                        r_state <= S_PK_SCAN;
                    end else if (r_i + CW'(1) == r_n) begin
                        r_i     <= '0;
                        r_state <= S_OUT_HEAD;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_PK_HEAD;
                    end
                end
                S_PK_SCAN: begin
                    if (r_dv && (first_q <= r_f) && (r_f <= final_q)) begin
                        r_alive <= r_alive + AW'(bytes_q);
                    end
                    if (scan_done) begin
                        if (r_alive > r_peak) begin
                            r_peak <= r_alive;
                        end
                        if (r_i + CW'(1) == r_n) begin
                            r_i     <= '0;
                            r_state <= S_OUT_HEAD;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_state <= S_PK_HEAD;
                        end
                    end
                end
                S_OUT_HEAD: r_state <= S_OUT_SL;
                S_OUT_SL:   r_state <= S_OUT_DAT;
                S_OUT_DAT: begin
                    if (!i_res_full) begin
                        if (r_i + CW'(1) == r_n) begin
                            r_n     <= '0;
                            r_slots <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_state <= S_OUT_HEAD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule

// ===== src/lifetime_aware_buffer_slot_planner.sv =====
// Buffer slot planner. Descriptor requests are queued and stored one per
// cycle while the planner is loading; planning starts after the request
// marked last (or the MAX_BUFFERS-th). Planning ranks buffers by size,
// assigns slots, sums totals and scans for the peak, each step bound by
// single-port descriptor and slot memories read one entry a cycle; then
// results are emitted one at a time in index order.
// Up to two descriptors of the next run are queued while a run is planned.
// depends on lasp_pkg, lasp_front, lasp_fifo, lasp_plan
module lifetime_aware_buffer_slot_planner #(
    parameter int MAX_BUFFERS = lasp_pkg::MAX_BUFFERS_DEF,
    parameter int SIZE_BITS   = lasp_pkg::SIZE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [lasp_pkg::BYTES_W-1:0]       i_buf_bytes,
    input  logic [lasp_pkg::STEP_W-1:0]        i_first_step,
    input  logic [lasp_pkg::STEP_W-1:0]        i_final_step,
    input  logic                               i_is_last,
    output logic                               empty,
    input  logic                               pop,
    output logic [lasp_pkg::INDEX_W-1:0]       o_buf_index,
    output logic [lasp_pkg::OUT_W-1:0]         o_byte_offset,
    output logic signed [lasp_pkg::OWNER_W-1:0] o_reuses_owner,
    output logic [lasp_pkg::OUT_W-1:0]         o_arena_total,
    output logic [lasp_pkg::OUT_W-1:0]         o_bytes_saved,
    output logic [lasp_pkg::OUT_W-1:0]         o_peak_live,
    output logic                               o_run_end
);
    localparam int DW = $bits(lasp_pkg::t_desc);
    localparam int RW = $bits(lasp_pkg::t_result);

    logic              q_wr;
    lasp_pkg::t_desc   q_wdata;
    logic              q_full;
    logic              q_empty;
    logic [DW-1:0]     q_rdata;
    logic              q_take;
    logic              r_push_w;
    lasp_pkg::t_result res;
    logic              res_full;
    logic [RW-1:0]     res_rdata;
    lasp_pkg::t_result res_out;

    lasp_front #(.MAX_BUFFERS(MAX_BUFFERS)) u_front (
        .i_clk, .i_rst_n, .push, .full,
        .i_buf_bytes, .i_first_step, .i_final_step, .i_is_last,
        .o_q_wr(q_wr), .o_q_data(q_wdata), .i_q_full(q_full)
    );

    lasp_fifo #(.W(DW)) u_in_q (
        .i_clk, .i_rst_n,
        .i_wr(q_wr), .i_data(q_wdata), .o_full(q_full),
        .i_rd(q_take), .o_data(q_rdata), .o_empty(q_empty)
    );

    lasp_plan #(.MAX_BUFFERS(MAX_BUFFERS), .SIZE_BITS(SIZE_BITS)) u_plan (
        .i_clk, .i_rst_n,
        .i_in_empty(q_empty), .i_in(lasp_pkg::t_desc'(q_rdata)), .o_in_take(q_take),
        .i_res_full(res_full), .o_res_push(r_push_w), .o_res(res)
    );

    lasp_fifo #(.W(RW)) u_out_q (
        .i_clk, .i_rst_n,
        .i_wr(r_push_w), .i_data(res), .o_full(res_full),
        .i_rd(pop), .o_data(res_rdata), .o_empty(empty)
    );

    assign res_out        = lasp_pkg::t_result'(res_rdata);
    assign o_buf_index    = res_out.buf_index;
    assign o_byte_offset  = res_out.byte_offset;
    assign o_reuses_owner = res_out.reuses_owner;
    assign o_arena_total  = res_out.arena_total;
    assign o_bytes_saved  = res_out.bytes_saved;
    assign o_peak_live    = res_out.peak_live;
    assign o_run_end      = res_out.run_end;
endmodule

// ===== src/lasp_checker.sv =====
// port-level checks of the buffer slot planner, bound to the top level
// depends on lasp_pkg and lifetime_aware_buffer_slot_planner
module lasp_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               empty,
    input logic                               pop,
    input logic [lasp_pkg::INDEX_W-1:0]       o_buf_index,
    input logic [lasp_pkg::OUT_W-1:0]         o_byte_offset,
    input logic signed [lasp_pkg::OWNER_W-1:0] o_reuses_owner,
    input logic [lasp_pkg::OUT_W-1:0]         o_arena_total,
    input logic [lasp_pkg::OUT_W-1:0]         o_bytes_saved,
    input logic [lasp_pkg::OUT_W-1:0]         o_peak_live,
    input logic                               o_run_end
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_buf_index) && $stable(o_byte_offset)))
        else $error("waiting result changed");

    a_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_reuses_owner != lasp_pkg::OWNER_W'(o_buf_index)))
        else $error("buffer reported as reusing its own slot");

    a_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_byte_offset <= o_arena_total))
        else $error("offset beyond arena");

    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_peak_live <= o_arena_total))
        else $error("peak live above arena total");
endmodule

bind lifetime_aware_buffer_slot_planner lasp_checker u_lasp_checker (.*);
